>>> rtl/rbfs_pkg.sv
// ----------------------------------------------------------------------------
// rbfs_pkg
// Shared types and constants of the region breadth-first splitter.
// ----------------------------------------------------------------------------
package rbfs_pkg;

    // Split mode register values
    localparam logic MODE_LONGEST = 1'b0;
    localparam logic MODE_XY      = 1'b1;

    // Cut axis codes
    typedef logic [1:0] t_axis;
    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    // Fixed result and port widths
    localparam int VOXEL_W = 31;
    localparam logic [VOXEL_W-1:0] VOXEL_MAX = {VOXEL_W{1'b1}};
    localparam int INDEX_W = 6;
    localparam int COUNT_IN_W = 7;
    localparam int APB_DATA_W = 32;

    // Status of the halving unit toward the sequencer
    typedef struct packed {
        logic  unit_volume;
        t_axis axis;
    } t_cut_status;

endpackage

>>> rtl/region_breadth_first_splitter_unit.sv
// ----------------------------------------------------------------------------
// region_breadth_first_splitter_unit
// Cuts a voxel box into the wanted number of parts, or fewer where a run stops
// short, breadth first, and emits the parts in table order.
// ----------------------------------------------------------------------------
// One box is handled at a time and the input is not ready until its last part
// has been taken. After the box is taken the block loads it into the table,
// then makes the cuts (one write through the single write port for each
// half), then emits each part by a table read and the two-stage voxel
// multiply, plus any output stall. A run that hits a single-voxel entry stops
// cutting there and flags every part it emits with cut_short. The table needs
// no clearing after reset: every entry read for a box is written earlier for
// that same box.
// ----------------------------------------------------------------------------
module region_breadth_first_splitter_unit #(
    parameter int MAX_PARTS  = 64,
    parameter int COORD_BITS = 16,
    parameter int SIZE_BITS  = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [rbfs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rbfs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // box input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [COORD_BITS-1:0]               i_start_i,
    input  logic [COORD_BITS-1:0]               i_start_j,
    input  logic [COORD_BITS-1:0]               i_start_k,
    input  logic [SIZE_BITS-1:0]                i_size_i,
    input  logic [SIZE_BITS-1:0]                i_size_j,
    input  logic [SIZE_BITS-1:0]                i_size_k,
    input  logic [rbfs_pkg::COUNT_IN_W-1:0]     i_part_count,
    // part output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [COORD_BITS-1:0]               o_part_start_i,
    output logic [COORD_BITS-1:0]               o_part_start_j,
    output logic [COORD_BITS-1:0]               o_part_start_k,
    output logic [SIZE_BITS-1:0]                o_part_size_i,
    output logic [SIZE_BITS-1:0]                o_part_size_j,
    output logic [SIZE_BITS-1:0]                o_part_size_k,
    output logic [rbfs_pkg::VOXEL_W-1:0]        o_part_voxels,
    output logic [rbfs_pkg::INDEX_W-1:0]        o_part_index,
    output logic                                o_cut_short,
    output logic                                o_last
);
    import rbfs_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_PARTS);
    localparam int CNT_W   = $clog2(MAX_PARTS + 1);
    localparam int START_W = 3 * COORD_BITS;
    localparam int SIZES_W = 3 * SIZE_BITS;
    localparam int ENTRY_W = START_W + SIZES_W;
    localparam int AB_W    = 2 * SIZE_BITS;
    localparam int PROD_W  = 3 * SIZE_BITS;
    localparam int WIDE_W  = (PROD_W > VOXEL_W) ? PROD_W : VOXEL_W;

    localparam logic REG_AXIS_MODE = 1'b0;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WAIT0 = 3'd1;
    localparam logic [2:0] S_SPLIT = 3'd2;
    localparam logic [2:0] S_UPPER = 3'd3;
    localparam logic [2:0] S_EWAIT = 3'd4;
    localparam logic [2:0] S_EMUL1 = 3'd5;
    localparam logic [2:0] S_EMUL2 = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // control state
    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_pass_end, n_pass_end;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_cut, n_cut;
    logic              r_mode;

    // table and datapath
    logic [ENTRY_W-1:0] r_table [MAX_PARTS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ENTRY_W-1:0] r_hi;
    logic               tbl_we;
    logic [ADDR_W-1:0]  tbl_wa;
    logic [ENTRY_W-1:0] tbl_wd;
    logic [ENTRY_W-1:0] in_word;
    logic [ENTRY_W-1:0] lo_word;
    logic [CNT_W-1:0]   in_count;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   fill_next;

    logic [2:0][COORD_BITS-1:0] rd_start;
    logic [2:0][SIZE_BITS-1:0]  rd_size;
    logic [2:0][SIZE_BITS-1:0]  lo_size;
    logic [2:0][COORD_BITS-1:0] hi_start;
    logic [2:0][SIZE_BITS-1:0]  hi_size;
    t_cut_status                cut_status;

    // output stage
    logic [2:0][COORD_BITS-1:0] r_o_start;
    logic [2:0][SIZE_BITS-1:0]  r_o_size;
    logic [AB_W-1:0]            r_ab;
    logic [VOXEL_W-1:0]         r_o_voxels;
    logic [INDEX_W-1:0]         r_o_index;
    logic                       r_o_cut;
    logic                       r_o_last;
    logic [WIDE_W-1:0]          prod;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_AXIS_MODE) ? APB_DATA_W'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LONGEST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_AXIS_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    // Pack the incoming box and clamp the part count
    assign in_word = {i_start_k, i_start_j, i_start_i, i_size_k, i_size_j, i_size_i};

    always_comb begin
        if (i_part_count == '0) begin
            in_count = CNT_W'(1);
        end else if (32'(i_part_count) > 32'(MAX_PARTS)) begin
            in_count = CNT_W'(MAX_PARTS);
        end else begin
            in_count = CNT_W'(i_part_count);
        end
    end

    // Unpack the entry read from the table
    assign rd_start = r_rd_data[ENTRY_W-1 -: START_W];
    assign rd_size  = r_rd_data[SIZES_W-1:0];

    rbfs_cut #(
        .COORD_BITS (COORD_BITS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_cut (
        .i_mode     (r_mode),
        .i_start    (rd_start),
        .i_size     (rd_size),
        .o_lo_size  (lo_size),
        .o_hi_start (hi_start),
        .o_hi_size  (hi_size),
        .o_status   (cut_status)
    );

    assign lo_word   = {rd_start, lo_size};
    assign idx_next  = CNT_W'(r_idx) + CNT_W'(1);
    assign fill_next = r_fill + CNT_W'(1);

    // Sequencer: load, halve entry by entry, then emit
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_fill     = r_fill;
        n_pass_end = r_pass_end;
        n_count    = r_count;
        n_cut      = r_cut;
        tbl_we     = 1'b0;
        tbl_wa     = r_idx;
        tbl_wd     = in_word;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    tbl_we     = 1'b1;
                    tbl_wa     = '0;
                    n_count    = in_count;
                    n_fill     = CNT_W'(1);
                    n_pass_end = CNT_W'(1);
                    n_cut      = 1'b0;
                    n_idx      = '0;
                    n_state    = (in_count == CNT_W'(1)) ? S_EWAIT : S_WAIT0;
                end
            end
            S_WAIT0: begin
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (cut_status.unit_volume) begin
                    n_cut   = 1'b1;
                    n_idx   = '0;
                    n_state = S_EMUL1;
                end else begin
                    tbl_we  = 1'b1;
                    tbl_wa  = r_idx;
                    tbl_wd  = lo_word;
                    n_state = S_UPPER;
                end
            end
            S_UPPER: begin
                tbl_we = 1'b1;
                tbl_wa = r_fill[ADDR_W-1:0];
                tbl_wd = r_hi;
                n_fill = fill_next;
                if (idx_next < r_pass_end && fill_next < r_count) begin
                    n_idx   = idx_next[ADDR_W-1:0];
                    n_state = S_SPLIT;
                end else begin
                    n_pass_end = fill_next;
                    n_idx      = '0;
                    n_state    = (fill_next < r_count) ? S_SPLIT : S_EMUL1;
                end
            end
            S_EWAIT: begin
                n_state = S_EMUL1;
            end
            S_EMUL1: begin
                n_state = S_EMUL2;
            end
            S_EMUL2: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = idx_next[ADDR_W-1:0];
                        n_state = S_EMUL1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_fill     <= '0;
            r_pass_end <= '0;
            r_count    <= '0;
            r_cut      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_fill     <= n_fill;
            r_pass_end <= n_pass_end;
            r_count    <= n_count;
            r_cut      <= n_cut;
        end
    end

    // Part table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_wa] <= tbl_wd;
        end
        r_rd_data <= r_table[n_idx];
    end

    // Hold the upper half until its write slot
    always_ff @(posedge i_clk) begin
        if (r_state == S_SPLIT) begin
            r_hi <= {hi_start, hi_size};
        end
    end

    // Emit path: capture the entry with the first of two multiply stages, saturate in the second
    assign prod = WIDE_W'(PROD_W'(r_ab) * PROD_W'(r_o_size[2]));

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMUL1) begin
            r_o_start <= rd_start;
            r_o_size  <= rd_size;
            r_ab      <= AB_W'(rd_size[0]) * AB_W'(rd_size[1]);
            r_o_index <= INDEX_W'(r_idx);
            r_o_cut   <= r_cut;
            r_o_last  <= (idx_next == r_fill);
        end
        if (r_state == S_EMUL2) begin
            r_o_voxels <= (prod > WIDE_W'(VOXEL_MAX)) ? VOXEL_MAX : VOXEL_W'(prod);
        end
    end

    // Drive the ports
    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_part_start_i = r_o_start[0];
    assign o_part_start_j = r_o_start[1];
    assign o_part_start_k = r_o_start[2];
    assign o_part_size_i  = r_o_size[0];
    assign o_part_size_j  = r_o_size[1];
    assign o_part_size_k  = r_o_size[2];
    assign o_part_voxels  = r_o_voxels;
    assign o_part_index   = r_o_index;
    assign o_cut_short    = r_o_cut;
    assign o_last         = r_o_last;

    // Table never grows past the wanted count
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_fill <= r_count && r_pass_end <= r_fill))
        else $error("fill count past part count or pass end past fill");

    // Only entries of the current pass are halved
    a_split_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (CNT_W'(r_idx) < r_pass_end))
        else $error("split index outside current pass");

    // XY mode never cuts z
    a_xy_no_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT && r_mode == MODE_XY) |-> (cut_status.axis != AXIS_Z))
        else $error("z axis cut in xy mode");

    // Taking the last part frees the input side
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> o_ready)
        else $error("input not ready after last part");

    // No new box while a part waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input ready while part pending");

endmodule

>>> rtl/rbfs_cut.sv
// ----------------------------------------------------------------------------
// rbfs_cut
// Halving unit: picks the cut axis of one table entry and forms both halves.
// ----------------------------------------------------------------------------
module rbfs_cut #(
    parameter int COORD_BITS = 16,
    parameter int SIZE_BITS  = 11
) (
    input  logic                             i_mode,
    input  logic [2:0][COORD_BITS-1:0]       i_start,
    input  logic [2:0][SIZE_BITS-1:0]        i_size,
    output logic [2:0][SIZE_BITS-1:0]        o_lo_size,
    output logic [2:0][COORD_BITS-1:0]       o_hi_start,
    output logic [2:0][SIZE_BITS-1:0]        o_hi_size,
    output rbfs_pkg::t_cut_status            o_status
);
    import rbfs_pkg::*;

    t_axis                 axis;
    logic [SIZE_BITS-1:0]  cut_size;
    logic [SIZE_BITS-1:0]  half;
    logic [COORD_BITS-1:0] cut_start;

    // Pick the longest axis, ties going x, then y, then z; XY mode picks y wherever x is not chosen
    always_comb begin
        if (i_size[0] >= i_size[1] && i_size[0] >= i_size[2]) begin
            axis = AXIS_X;
        end else if (i_mode == MODE_XY || i_size[1] >= i_size[2]) begin
            axis = AXIS_Y;
        end else begin
            axis = AXIS_Z;
        end
    end

    // Select the extent and start of the cut axis
    always_comb begin
        case (axis)
            AXIS_X: begin
                cut_size  = i_size[0];
                cut_start = i_start[0];
            end
            AXIS_Y: begin
                cut_size  = i_size[1];
                cut_start = i_start[1];
            end
            AXIS_Z: begin
                cut_size  = i_size[2];
                cut_start = i_start[2];
            end
            default: begin
                cut_size  = i_size[0];
                cut_start = i_start[0];
            end
        endcase
    end

    assign half = cut_size >> 1;

    // Lower half keeps floor(n/2), upper half takes the rest
    always_comb begin
        o_lo_size  = i_size;
        o_hi_start = i_start;
        o_hi_size  = i_size;
        for (int a = 0; a < 3; a++) begin
            if (axis == t_axis'(a)) begin
                o_lo_size[a]  = half;
                o_hi_start[a] = cut_start + COORD_BITS'(half);
                o_hi_size[a]  = cut_size - half;
            end
        end
    end

    // A single-voxel entry stops the run
    assign o_status.unit_volume = (i_size[0] == SIZE_BITS'(1)) &&
                                  (i_size[1] == SIZE_BITS'(1)) &&
                                  (i_size[2] == SIZE_BITS'(1));
    assign o_status.axis = axis;

endmodule
